/* rtl/task_timer_slot_table_defines.svh */
// assertion macros for the timer slot table
`ifndef TASK_TIMER_SLOT_TABLE_DEFINES_SVH
`define TASK_TIMER_SLOT_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
`define TTST_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");
`define TTST_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");
`else
`define TTST_ASSERT(lbl, prop)
`define TTST_ASSERT_RST(lbl, prop)
`endif

`endif

/* rtl/ttst_pkg.sv */
// shared types and constants for the timer slot table
`default_nettype none

package ttst_pkg;

  localparam int NUM_SLOTS   = 8;
  localparam int COUNT_WIDTH = 16;
  localparam int NUM_TASKS   = 8;
  localparam int TASK_WIDTH  = 3;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [TASK_WIDTH-1:0]  task_t;
  typedef logic [NUM_TASKS-1:0]   task_mask_t;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_SET   = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_NONE   = 2'd0,
    ST_RELOAD = 2'd1,
    ST_NEW    = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef struct packed {
    logic       match;
    logic       free;
    task_mask_t fire;
  } chain_t;

endpackage

`default_nettype wire

/* rtl/ttst_cell.sv */
// one timer slot of the chain
`default_nettype none

module ttst_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req,
  input  wire ttst_pkg::cmd_t    cmd,
  input  wire ttst_pkg::task_t   req_task,
  input  wire ttst_pkg::count_t  req_time,
  input  wire logic              any_match,
  input  wire ttst_pkg::chain_t  chain_in,
  output ttst_pkg::chain_t       chain_out
);

  logic                valid;
  ttst_pkg::task_t     slot_task;
  ttst_pkg::count_t    count;
  logic                hit;
  logic                reload;
  logic                take;
  logic                fire;
  logic                do_tick;
  ttst_pkg::task_mask_t fire_bit;

  assign do_tick = req && (cmd == ttst_pkg::CMD_TICK);
  assign hit     = valid && (slot_task == req_task);
  assign reload  = req && (cmd == ttst_pkg::CMD_SET) && hit && !chain_in.match;
  assign take    = req && (cmd == ttst_pkg::CMD_SET) && !any_match && !valid
                   && !chain_in.free;
  assign fire    = do_tick && valid && (count == '0);

  always_comb begin
    fire_bit            = '0;
    fire_bit[slot_task] = fire;
  end

  assign chain_out.match = chain_in.match | hit;
  assign chain_out.free  = chain_in.free | !valid;
  assign chain_out.fire  = chain_in.fire | fire_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= 1'b1;
    end else if (fire) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      slot_task <= req_task;
    end
    if (take || reload) begin
      count <= req_time;
    end else if (do_tick && valid && (count != '0)) begin
      count <= count - ttst_pkg::count_t'(1);
    end
  end

endmodule

`default_nettype wire

/* rtl/task_timer_slot_table.sv */
// timer slot table top level
// One command is taken in every cycle: busy never rises. The result of a command
// is strobed on done in the cycle after start, for exactly one cycle, and cannot
// be held off. The slot search runs as a combinational priority chain through the NUM_SLOTS
// cells, so the chain length sets the clock period.
`default_nettype none
`include "task_timer_slot_table_defines.svh"

module task_timer_slot_table (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  cmd,
  input  wire logic [2:0]  task_id,
  input  wire logic [15:0] time_ticks,
  output logic             done,
  output logic [7:0]       pending_flags,
  output logic [1:0]       set_status
);

  logic                 req;
  ttst_pkg::cmd_t       cmd_op;
  ttst_pkg::count_t     time_val;
  ttst_pkg::chain_t     chain [ttst_pkg::NUM_SLOTS+1];
  logic                 any_match;
  ttst_pkg::task_mask_t pending;
  ttst_pkg::task_mask_t pending_next;
  ttst_pkg::task_mask_t clear_bit;
  ttst_pkg::status_t    status;
  ttst_pkg::status_t    status_next;

  assign busy     = 1'b0;
  assign req      = start && !busy;
  assign cmd_op   = ttst_pkg::cmd_t'(cmd);
  assign time_val = ttst_pkg::count_t'(time_ticks);

  assign chain[0] = '0;

  for (genvar i = 0; i < ttst_pkg::NUM_SLOTS; i++) begin : g_cell
    ttst_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .req       (req),
      .cmd       (cmd_op),
      .req_task  (task_id),
      .req_time  (time_val),
      .any_match (any_match),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1])
    );
  end

  assign any_match = chain[ttst_pkg::NUM_SLOTS].match;

  always_comb begin
    clear_bit          = '0;
    clear_bit[task_id] = 1'b1;
    pending_next       = pending;
    status_next        = ttst_pkg::ST_NONE;
    case (cmd_op)
      ttst_pkg::CMD_TICK: begin
        pending_next = pending | chain[ttst_pkg::NUM_SLOTS].fire;
      end
      ttst_pkg::CMD_SET: begin
        if (any_match) begin
          status_next = ttst_pkg::ST_RELOAD;
        end else if (chain[ttst_pkg::NUM_SLOTS].free) begin
          status_next = ttst_pkg::ST_NEW;
        end else begin
          status_next = ttst_pkg::ST_FULL;
        end
      end
      ttst_pkg::CMD_CLEAR: begin
        pending_next = pending & ~clear_bit;
      end
      default: begin
        pending_next = pending;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      done    <= 1'b0;
      status  <= ttst_pkg::ST_NONE;
    end else begin
      done <= req;
      if (req) begin
        pending <= pending_next;
        status  <= status_next;
      end
    end
  end

  assign pending_flags = pending;
  assign set_status    = status;

  `TTST_ASSERT(a_done_follows_request, done |-> $past(req))
  `TTST_ASSERT(a_status_only_on_set,
    (done && (set_status != ttst_pkg::ST_NONE)) |-> ($past(cmd) == ttst_pkg::CMD_SET))
  `TTST_ASSERT(a_clear_drops_bit,
    (done && ($past(cmd) == ttst_pkg::CMD_CLEAR)) |-> (pending_flags[$past(task_id)] == 1'b0))
  `TTST_ASSERT(a_tick_keeps_bits,
    (done && ($past(cmd) == ttst_pkg::CMD_TICK)) |->
      ((pending_flags & $past(pending_flags)) == $past(pending_flags)))
  `TTST_ASSERT_RST(a_reset_quiet, rst |=> !done)

endmodule

`default_nettype wire

/* tb/tb_task_timer_slot_table.sv */
// self-checking testbench for the timer slot table: directed table, then random requests
`default_nettype none

module tb_task_timer_slot_table;
  import ttst_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_REQUESTS = 1800;
  localparam int CYCLE_LIMIT = 100000;
  localparam int NUM_DIRECTED = 24;

  typedef struct {
    logic [7:0] pending;
    status_t    status;
  } timer_report_t;

  typedef struct {
    logic [1:0]  op;
    task_t       tid;
    logic [15:0] ticks;
    bit          typed;
    logic [7:0]  pending;
    status_t     status;
  } request_row_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  cmd;
  logic [2:0]  task_id;
  logic [15:0] time_ticks;
  logic        done;
  logic [7:0]  pending_flags;
  logic [1:0]  set_status;

  // local copy of the slot table
  bit         model_valid [NUM_SLOTS];
  task_t      model_task [NUM_SLOTS];
  count_t     model_count [NUM_SLOTS];
  task_mask_t model_pending;

  timer_report_t report_q[$];
  int err_count;
  int cycle_count;

  request_row_t directed_rows [NUM_DIRECTED] = '{
    '{CMD_TICK,   3'd0, 16'h0000, 1'b1, 8'h00, ST_NONE},
    '{CMD_UNUSED, 3'd7, 16'hffff, 1'b1, 8'h00, ST_NONE},
    '{CMD_CLEAR,  3'd5, 16'h0000, 1'b1, 8'h00, ST_NONE},
    '{CMD_SET,    3'd0, 16'h0000, 1'b1, 8'h00, ST_NEW},
    '{CMD_SET,    3'd0, 16'hffff, 1'b1, 8'h00, ST_RELOAD},
    '{CMD_SET,    3'd0, 16'h0000, 1'b1, 8'h00, ST_RELOAD},
    '{CMD_TICK,   3'd0, 16'h0000, 1'b1, 8'h01, ST_NONE},
    '{CMD_SET,    3'd1, 16'h0000, 1'b1, 8'h01, ST_NEW},
    '{CMD_SET,    3'd2, 16'h0000, 1'b1, 8'h01, ST_NEW},
    '{CMD_SET,    3'd3, 16'h0005, 1'b1, 8'h01, ST_NEW},
    '{CMD_SET,    3'd4, 16'h0000, 1'b1, 8'h01, ST_NEW},
    '{CMD_SET,    3'd5, 16'h0000, 1'b1, 8'h01, ST_NEW},
    '{CMD_SET,    3'd6, 16'h0000, 1'b1, 8'h01, ST_NEW},
    '{CMD_SET,    3'd7, 16'h0000, 1'b1, 8'h01, ST_NEW},
    '{CMD_SET,    3'd0, 16'h0001, 1'b1, 8'h01, ST_NEW},
    '{CMD_TICK,   3'd0, 16'h0000, 1'b1, 8'hf7, ST_NONE},
    '{CMD_CLEAR,  3'd0, 16'h0000, 1'b1, 8'hf6, ST_NONE},
    '{CMD_SET,    3'd1, 16'h0002, 1'b0, 8'h00, ST_NONE},
    '{CMD_TICK,   3'd0, 16'h0000, 1'b0, 8'h00, ST_NONE},
    '{CMD_SET,    3'd3, 16'h5a5a, 1'b0, 8'h00, ST_NONE},
    '{CMD_TICK,   3'd0, 16'h0000, 1'b0, 8'h00, ST_NONE},
    '{CMD_CLEAR,  3'd7, 16'hffff, 1'b0, 8'h00, ST_NONE},
    '{CMD_TICK,   3'd0, 16'h0000, 1'b0, 8'h00, ST_NONE},
    '{CMD_UNUSED, 3'd2, 16'h1234, 1'b0, 8'h00, ST_NONE}
  };

  task_timer_slot_table uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .task_id(task_id),
    .time_ticks(time_ticks),
    .done(done),
    .pending_flags(pending_flags),
    .set_status(set_status)
  );

  always #4 clk = ~clk;

  function automatic timer_report_t timer_table_step(logic [1:0] op, task_t tid,
                                                     logic [15:0] ticks);
    timer_report_t r;
    bit found;
    r.status = ST_NONE;
    found = 1'b0;
    case (op)
      CMD_TICK: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (model_valid[i]) begin
            if (model_count[i] != '0) begin
              model_count[i] = model_count[i] - 1'b1;
            end else begin
              model_pending[model_task[i]] = 1'b1;
              model_valid[i] = 1'b0;
            end
          end
        end
      end
      CMD_SET: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (!found && model_valid[i] && model_task[i] == tid) begin
            model_count[i] = count_t'(ticks);
            r.status = ST_RELOAD;
            found = 1'b1;
          end
        end
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (!found && !model_valid[i]) begin
            model_valid[i] = 1'b1;
            model_task[i] = tid;
            model_count[i] = count_t'(ticks);
            r.status = ST_NEW;
            found = 1'b1;
          end
        end
        if (!found) r.status = ST_FULL;
      end
      CMD_CLEAR: begin
        model_pending[tid] = 1'b0;
      end
      default: ;
    endcase
    r.pending = model_pending;
    return r;
  endfunction

  task automatic issue(input logic [1:0] op, input task_t tid, input logic [15:0] ticks,
                       input bit typed, input logic [7:0] pend, input status_t st);
    timer_report_t r;
    start <= 1'b1;
    cmd <= op;
    task_id <= tid;
    time_ticks <= ticks;
    do @(posedge clk); while (busy);
    r = timer_table_step(op, tid, ticks);
    if (typed) begin
      r.pending = pend;
      r.status = st;
    end
    report_q.push_back(r);
  endtask

  task automatic idle_cycles(input int n);
    start <= 1'b0;
    cmd <= 2'($urandom);
    task_id <= 3'($urandom);
    time_ticks <= 16'($urandom);
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_reports();
    start <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    timer_report_t exp_r;
    if (!rst && done) begin
      if (report_q.size() == 0) begin
        $error("unexpected result: pending_flags %h set_status %0d", pending_flags,
               set_status);
        err_count++;
      end else begin
        exp_r = report_q.pop_front();
        if (pending_flags !== exp_r.pending) begin
          $error("pending_flags: expected %h, actual %h", exp_r.pending, pending_flags);
          err_count++;
        end
        if (set_status !== exp_r.status) begin
          $error("set_status: expected %0d, actual %0d", exp_r.status, set_status);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_task_timer_slot_table: done, errors");
      $finish;
    end
  end

  initial begin
    int k;
    logic [1:0] op;
    logic [15:0] ticks;
    clk = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    task_id = '0;
    time_ticks = '0;
    err_count = 0;
    cycle_count = 0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      model_valid[i] = 1'b0;
      model_task[i] = '0;
      model_count[i] = '0;
    end
    model_pending = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      issue(directed_rows[i].op, directed_rows[i].tid, directed_rows[i].ticks,
            directed_rows[i].typed, directed_rows[i].pending, directed_rows[i].status);
    end
    drain_reports();

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == 1200) drain_reports();
      if (!(n >= 600 && n < 1000) && $urandom_range(99) < 7)
        idle_cycles($urandom_range(3, 1));
      k = $urandom_range(99);
      ticks = 16'($urandom);
      if (k < 40) begin
        op = CMD_TICK;
      end else if (k < 75) begin
        op = CMD_SET;
        // short counts so slots fire and free up often
        if ($urandom_range(19) != 0) ticks = 16'($urandom_range(8));
      end else if (k < 95) begin
        op = CMD_CLEAR;
      end else begin
        op = CMD_UNUSED;
      end
      issue(op, 3'($urandom), ticks, 1'b0, 8'h00, ST_NONE);
    end

    drain_reports();
    repeat (4) @(posedge clk);
    if (err_count == 0)
      $display("tb_task_timer_slot_table: done, clean");
    else
      $display("tb_task_timer_slot_table: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
